[rtl/scws_pkg.sv]
package scws_pkg;

    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_LBR    = 8'h5B;
    localparam logic [7:0] CHAR_RBR    = 8'h5D;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    localparam int WINDOW_DEPTH = 3;
    localparam int MAX_RESULTS  = 4;

    typedef struct packed {
        logic [1:0] skip;
        logic [7:0] prev;
        logic       seen;
        logic       in_str;
        logic [7:0] quote;
        logic       in_line;
        logic       in_block;
        logic       after_space;
    } dec_state_t;

    typedef struct packed {
        dec_state_t st;
        logic       emit;
        logic [7:0] data;
    } dec_result_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CHAR_SPACE) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    // decide one byte given the byte after it and whether "[[" follows the pair
    function automatic dec_result_t decide(dec_state_t s, logic [7:0] c, logic [7:0] nx,
                                           logic has_nx, logic blk);
        dec_result_t r;
        r.st   = s;
        r.emit = 1'b0;
        r.data = c;
        if (s.skip != 2'd0)
        begin
            r.st.skip = s.skip - 2'd1;
        end
        else if (!s.in_line && !s.in_block && (c == CHAR_DQUOTE || c == CHAR_SQUOTE))
        begin
            if (!s.in_str)
            begin
                r.st.in_str = 1'b1;
                r.st.quote  = c;
            end
            else if (c == s.quote && s.seen && s.prev != CHAR_BSLASH)
            begin
                r.st.in_str = 1'b0;
            end
            r.emit = 1'b1;
        end
        else if (!s.in_str && !s.in_line && !s.in_block && c == CHAR_DASH && nx == CHAR_DASH)
        begin
            if (blk)
            begin
                r.st.in_block = 1'b1;
                r.st.skip     = 2'd3;
            end
            else
            begin
                r.st.in_line = 1'b1;
            end
        end
        else if (s.in_block && c == CHAR_RBR && nx == CHAR_RBR)
        begin
            r.st.in_block = 1'b0;
            r.st.skip     = 2'd1;
        end
        else if (s.in_line && c == CHAR_NL)
        begin
            r.st.in_line = 1'b0;
            r.emit       = 1'b1;
        end
        else if (s.in_line || s.in_block)
        begin
            r.emit = 1'b0;
        end
        else if (is_ws(c))
        begin
            if (s.in_str)
            begin
                r.emit = 1'b1;
            end
            else if (!s.after_space && s.seen && has_nx && is_alnum(s.prev) && is_alnum(nx))
            begin
                r.emit = 1'b1;
                r.data = CHAR_SPACE;
            end
            r.st.after_space = 1'b1;
        end
        else
        begin
            r.st.after_space = 1'b0;
            r.emit           = 1'b1;
        end
        r.st.prev = c;
        r.st.seen = 1'b1;
        return r;
    endfunction

endpackage

[rtl/script_comment_whitespace_stripper_core.sv]
// result words of a taken input word are registered in the result queue for the master side
// throughput: one input word per cycle while the queue is empty or its last word drains;
// an end-of-text word yields up to four words, drained one per cycle while m_tready is high
// a byte is decided once two later bytes are in the lookahead window and a third arrives
// reset: asynchronous active-low, clears the window count, scanner flags and result count
module script_comment_whitespace_stripper_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tuser,   // has_byte
    output logic       m_tlast    // out_last
);

    scws_pkg::dec_state_t  state_reg, state_next;
    logic [7:0]            la_reg [scws_pkg::WINDOW_DEPTH];
    logic [7:0]            la_next [scws_pkg::WINDOW_DEPTH];
    logic [1:0]            wcount_reg, wcount_next;
    logic [7:0]            q_reg [scws_pkg::MAX_RESULTS];
    logic [7:0]            q_next [scws_pkg::MAX_RESULTS];
    logic [2:0]            rem_reg, rem_next;
    logic                  last_reg, last_next;
    logic                  bare_reg, bare_next;

    logic                  accept;
    logic                  drain;
    logic [7:0]            buf_b [scws_pkg::MAX_RESULTS + 1];
    logic [2:0]            fill;
    scws_pkg::dec_state_t  chain [scws_pkg::MAX_RESULTS + 1];
    scws_pkg::dec_result_t res [scws_pkg::MAX_RESULTS];
    scws_pkg::dec_result_t dn;
    logic [7:0]            flush_q [scws_pkg::MAX_RESULTS];
    logic [2:0]            flush_cnt;

    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = q_reg[0];
    assign m_tuser  = !bare_reg;
    assign m_tlast  = last_reg && (rem_reg == 3'd1);
    assign drain    = m_tvalid && m_tready;
    assign s_tready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);
    assign accept   = s_tvalid && s_tready;

    // steady-state decision on the oldest window byte
    assign dn = scws_pkg::decide(state_reg, la_reg[0], la_reg[1], 1'b1,
                                 (la_reg[2] == scws_pkg::CHAR_LBR) &&
                                 (s_tdata == scws_pkg::CHAR_LBR));

    // flush path: window plus the new byte, zero beyond
    always_comb
    begin
        fill = {1'b0, wcount_reg} + 3'd1;
        for (int i = 0; i < scws_pkg::WINDOW_DEPTH; i++)
        begin
            if (2'(i) < wcount_reg)
                buf_b[i] = la_reg[i];
            else if (2'(i) == wcount_reg)
                buf_b[i] = s_tdata;
            else
                buf_b[i] = 8'd0;
        end
        buf_b[3] = (wcount_reg == 2'd3) ? s_tdata : 8'd0;
        buf_b[4] = 8'd0;

        chain[0] = state_reg;
        for (int p = 0; p < scws_pkg::MAX_RESULTS; p++)
        begin
            res[p] = scws_pkg::decide(chain[p], buf_b[p], buf_b[p + 1],
                                      (3'(p + 1) < fill),
                                      (p == 0) && (fill == 3'd4) &&
                                      (buf_b[2] == scws_pkg::CHAR_LBR) &&
                                      (buf_b[3] == scws_pkg::CHAR_LBR));
            chain[p + 1] = (3'(p) < fill) ? res[p].st : chain[p];
        end

        flush_cnt = 3'd0;
        for (int k = 0; k < scws_pkg::MAX_RESULTS; k++)
            flush_q[k] = 8'd0;
        for (int p = 0; p < scws_pkg::MAX_RESULTS; p++)
        begin
            if ((3'(p) < fill) && res[p].emit)
            begin
                flush_q[flush_cnt[1:0]] = res[p].data;
                flush_cnt               = flush_cnt + 3'd1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        la_next     = la_reg;
        wcount_next = wcount_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        last_next   = last_reg;
        bare_next   = bare_reg;

        if (drain)
        begin
            for (int k = 0; k < scws_pkg::MAX_RESULTS - 1; k++)
                q_next[k] = q_reg[k + 1];
            rem_next = rem_reg - 3'd1;
        end

        if (accept)
        begin
            if (s_tlast)
            begin
                state_next  = '0;
                wcount_next = 2'd0;
                q_next      = flush_q;
                last_next   = 1'b1;
                if (flush_cnt == 3'd0)
                begin
                    rem_next  = 3'd1;
                    bare_next = 1'b1;
                end
                else
                begin
                    rem_next  = flush_cnt;
                    bare_next = 1'b0;
                end
            end
            else
            begin
                last_next = 1'b0;
                bare_next = 1'b0;
                if (wcount_reg == 2'd3)
                begin
                    state_next = dn.st;
                    la_next[0] = la_reg[1];
                    la_next[1] = la_reg[2];
                    la_next[2] = s_tdata;
                    q_next[0]  = dn.data;
                    rem_next   = dn.emit ? 3'd1 : 3'd0;
                end
                else
                begin
                    la_next[wcount_reg] = s_tdata;
                    wcount_next         = wcount_reg + 2'd1;
                    rem_next            = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wcount_reg <= 2'd0;
            rem_reg    <= 3'd0;
            last_reg   <= 1'b0;
            bare_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wcount_reg <= wcount_next;
            rem_reg    <= rem_next;
            last_reg   <= last_next;
            bare_reg   <= bare_next;
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg <= la_next;
        q_reg  <= q_next;
    end

endmodule
